### hdl/indexed_array_list_defines.svh
// Assertion macros shared by the checker.
`ifndef INDEXED_ARRAY_LIST_DEFINES_SVH
`define INDEXED_ARRAY_LIST_DEFINES_SVH

// same-cycle implication
`define IAL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("indexed_array_list assertion failed");

// next-cycle implication
`define IAL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("indexed_array_list assertion failed");

`endif

### hdl/ial_pkg.sv
package ial_pkg;

    localparam int CAPACITY = 64;
    localparam int ELEM_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > 7) ? CNT_W : 7;

    localparam logic [2:0] OP_GET    = 3'd0;
    localparam logic [2:0] OP_SET    = 3'd1;
    localparam logic [2:0] OP_INSERT = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_RESIZE = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [6:0]  index;
        logic [31:0] value;
        logic [6:0]  new_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic [6:0]  length;
    } t_out_item;

    // broadcast from control to every cell
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic              set;
        logic [CMP_W-1:0]  idx;
        logic [CMP_W-1:0]  cnt;
        logic [ELEM_W-1:0] value;
    } t_cell_ctl;

endpackage

### hdl/ial_cell.sv
module ial_cell
    import ial_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CMP_W-1:0]  i_pos,
    input  t_cell_ctl         i_ctl,
    input  logic [ELEM_W-1:0] i_left,
    input  logic [ELEM_W-1:0] i_right,
    output logic [ELEM_W-1:0] o_data,
    output logic [ELEM_W-1:0] o_rd
);

    logic [ELEM_W-1:0] r_data;
    logic [ELEM_W-1:0] n_data;
    logic              hit;
    logic              above;
    logic              in_live;
    logic              pull_right;

    always_comb begin
        hit        = (i_pos == i_ctl.idx);
        above      = (i_pos > i_ctl.idx);
        in_live    = (i_pos <= i_ctl.cnt);
        pull_right = ({1'b0, i_pos} + (CMP_W + 1)'(1)) < {1'b0, i_ctl.cnt};
        n_data     = r_data;
        if (i_ctl.set && hit) begin
            n_data = i_ctl.value;
        end else if (i_ctl.ins) begin
            if (hit) begin
                n_data = i_ctl.value;
            end else if (above && in_live) begin
                n_data = i_left;
            end
        end else if (i_ctl.rem && (hit || above) && pull_right) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;
    assign o_rd   = hit ? r_data : '0;

endmodule

### hdl/ial_ctrl.sv
module ial_ctrl
    import ial_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    input  logic [ELEM_W-1:0] i_rd_data,
    output t_cell_ctl         o_ctl,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_out_item        r_out;
    logic             fire;
    logic [CMP_W-1:0] idx_x;
    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] req_x;
    logic [CMP_W-1:0] cap_x;
    logic [1:0]       status;
    logic             rd_ok;
    logic             do_ins;
    logic             do_rem;
    logic             do_set;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign fire       = i_in_valid && o_in_ready;

    always_comb begin
        idx_x   = CMP_W'(i_in_data.index);
        cnt_x   = CMP_W'(r_count);
        req_x   = CMP_W'(i_in_data.new_length);
        cap_x   = CMP_W'(CAPACITY);
        status  = ST_OK;
        rd_ok   = 1'b0;
        do_ins  = 1'b0;
        do_rem  = 1'b0;
        do_set  = 1'b0;
        n_count = r_count;
        unique case (i_in_data.op)
            OP_GET: begin
                if (idx_x >= cnt_x) status = ST_RANGE;
                else rd_ok = 1'b1;
            end
            OP_SET: begin
                if (idx_x >= cnt_x) status = ST_RANGE;
                else do_set = 1'b1;
            end
            OP_INSERT: begin
                if (idx_x > cnt_x) begin
                    status = ST_RANGE;
                end else if (cnt_x >= cap_x) begin
                    status = ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    n_count = CNT_W'(r_count + 1'b1);
                end
            end
            OP_REMOVE: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else if (idx_x >= cnt_x) begin
                    status = ST_RANGE;
                end else begin
                    do_rem  = 1'b1;
                    n_count = CNT_W'(r_count - 1'b1);
                end
            end
            OP_RESIZE: begin
                if (req_x > cap_x) status = ST_FULL;
                else n_count = CNT_W'(req_x);
            end
            OP_CLEAR: n_count = '0;
            default: ;
        endcase
    end

    always_comb begin
        o_ctl.ins   = fire && do_ins;
        o_ctl.rem   = fire && do_rem;
        o_ctl.set   = fire && do_set;
        o_ctl.idx   = idx_x;
        o_ctl.cnt   = cnt_x;
        o_ctl.value = ELEM_W'(i_in_data.value);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_count     <= n_count;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.status     <= status;
            r_out.read_value <= rd_ok ? 32'(i_rd_data) : 32'd0;
            r_out.length     <= 7'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### hdl/indexed_array_list.sv
// Ordered array of CAPACITY elements with a live length, one operation per item
// (get, set, insert, remove, resize, clear) and exactly one result per item.
// An item is accepted every cycle while the result register is free or being
// drained; its result appears in the cycle after acceptance. Each element sits
// in its own cell of a chain, so insert and remove shift all later elements in
// the same cycle, and get reads through an AND-OR across the cells. Reset
// clears the store and the length in the same cycle; no sweep follows.
module indexed_array_list
    import ial_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_cell_ctl         ctl;
    logic [ELEM_W-1:0] cell_data [CAPACITY];
    logic [ELEM_W-1:0] cell_rd   [CAPACITY];
    logic [ELEM_W-1:0] rd_data;

    ial_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_rd_data   (rd_data),
        .o_ctl       (ctl),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ELEM_W-1:0] left;
        logic [ELEM_W-1:0] right;

        assign left  = (g == 0) ? ctl.value : cell_data[(g == 0) ? 0 : g - 1];
        assign right = (g == CAPACITY - 1) ? cell_data[g]
                                           : cell_data[(g == CAPACITY - 1) ? g : g + 1];

        ial_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pos   (CMP_W'(g)),
            .i_ctl   (ctl),
            .i_left  (left),
            .i_right (right),
            .o_data  (cell_data[g]),
            .o_rd    (cell_rd[g])
        );
    end

    always_comb begin
        rd_data = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_data = rd_data | cell_rd[k];
        end
    end

endmodule

### hdl/ial_checker.sv
`include "indexed_array_list_defines.svh"

module ial_checker
    import ial_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    logic       in_fire;
    logic       out_stall;
    logic       out_err;
    logic       clear_fire;
    logic       resize_fire;
    logic [6:0] len_out;
    logic [6:0] req_len;
    logic [1:0] out_st;

    assign in_fire     = i_in_valid && o_in_ready;
    assign out_stall   = o_out_valid && !i_out_ready;
    assign out_err     = o_out_valid && (o_out_data.status != ST_OK);
    assign clear_fire  = in_fire && (i_in_data.op == OP_CLEAR);
    assign resize_fire = in_fire && (i_in_data.op == OP_RESIZE)
                         && (CMP_W'(i_in_data.new_length) <= CMP_W'(CAPACITY));
    assign len_out     = o_out_data.length;
    assign req_len     = i_in_data.new_length;
    assign out_st      = o_out_data.status;

    `IAL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_data))
    `IAL_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, in_fire, o_out_valid)
    `IAL_ASSERT_NOW(a_err_no_data, i_clk, i_rst_n, out_err, o_out_data.read_value == 32'd0)
    `IAL_ASSERT_NXT(a_clear_len, i_clk, i_rst_n, clear_fire, len_out == 7'd0 && out_st == ST_OK)
    `IAL_ASSERT_NXT(a_resize_len, i_clk, i_rst_n, resize_fire, len_out == $past(req_len))

endmodule

bind indexed_array_list ial_checker u_ial_checker (.*);

### dv/indexed_array_list_tb.sv
`timescale 1ns / 100ps

module indexed_array_list_tb;
    import ial_pkg::*;

    localparam logic [2:0] OP_UNUSED_LO = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    localparam int RANDOM_ITEMS    = 1400;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 8;

    typedef enum logic [1:0] {
        IDLE_SRC_LIGHT,
        IDLE_DST_LIGHT,
        IDLE_NONE
    } t_idle_mode;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    logic [ELEM_W-1:0] shadow_store [CAPACITY];
    int unsigned       shadow_len;
    t_out_item         reply_q [$];
    t_out_item         head_reply;
    t_idle_mode        idle_mode = IDLE_SRC_LIGHT;
    int                err_cnt = 0;
    int                quiet_cycles = 0;

    indexed_array_list dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned idle_pct(input bit rx_side);
        case (idle_mode)
            IDLE_SRC_LIGHT: return rx_side ? 80 : 10;
            IDLE_DST_LIGHT: return rx_side ? 10 : 80;
            default:        return 0;
        endcase
    endfunction

    // applies one item to the shadow array and returns its result
    function automatic t_out_item list_op_reply(input t_in_item it);
        t_out_item   r;
        int unsigned idx;
        int unsigned i;
        r   = '0;
        idx = it.index;
        case (it.op)
            OP_GET: begin
                if (idx >= shadow_len) r.status = ST_RANGE;
                else r.read_value = 32'(shadow_store[idx]);
            end
            OP_SET: begin
                if (idx >= shadow_len) r.status = ST_RANGE;
                else shadow_store[idx] = ELEM_W'(it.value);
            end
            OP_INSERT: begin
                if (idx > shadow_len) begin
                    r.status = ST_RANGE;
                end else if (shadow_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = shadow_len; i > idx; i--) shadow_store[i] = shadow_store[i - 1];
                    shadow_store[idx] = ELEM_W'(it.value);
                    shadow_len++;
                end
            end
            OP_REMOVE: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (idx >= shadow_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = idx; i + 1 < shadow_len; i++) shadow_store[i] = shadow_store[i + 1];
                    shadow_len--;
                end
            end
            OP_RESIZE: begin
                if (it.new_length > CAPACITY) r.status = ST_FULL;
                else shadow_len = it.new_length;
            end
            OP_CLEAR: shadow_len = 0;
            default: ;
        endcase
        r.length = 7'(shadow_len);
        return r;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item    it;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 22)      it.op = OP_GET;
        else if (pick < 36) it.op = OP_SET;
        else if (pick < 60) it.op = OP_INSERT;
        else if (pick < 80) it.op = OP_REMOVE;
        else if (pick < 89) it.op = OP_RESIZE;
        else if (pick < 92) it.op = OP_CLEAR;
        else                it.op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));

        pick = $urandom_range(99);
        if (pick < 70)      it.index = 7'($urandom_range(shadow_len));
        else if (pick < 90) it.index = 7'($urandom_range(CAPACITY));
        else                it.index = 7'($urandom);

        pick = $urandom_range(99);
        if (pick < 10)      it.value = '0;
        else if (pick < 20) it.value = '1;
        else                it.value = $urandom;

        pick = $urandom_range(99);
        if (pick < 70)      it.new_length = 7'($urandom_range(CAPACITY));
        else if (pick < 85) it.new_length = 7'(CAPACITY);
        else                it.new_length = 7'($urandom);
        return it;
    endfunction

    function automatic t_dir_row dir_row(input logic [2:0] op, input logic [6:0] idx,
                                         input logic [31:0] val, input logic [6:0] req,
                                         input bit typed, input logic [1:0] st,
                                         input logic [31:0] rd, input logic [6:0] len);
        t_dir_row r;
        r.item.op         = op;
        r.item.index      = idx;
        r.item.value      = val;
        r.item.new_length = req;
        r.typed           = typed;
        r.want.status     = st;
        r.want.read_value = rd;
        r.want.length     = len;
        return r;
    endfunction

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item model_reply;
        while ($urandom_range(99) < idle_pct(1'b0)) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        model_reply = list_op_reply(it);
        reply_q.push_back(typed ? want : model_reply);
    endtask

    initial begin
        t_dir_row dir_rows [$];
        int       k;
        for (k = 0; k < CAPACITY; k++) shadow_store[k] = '0;
        shadow_len = 0;

        dir_rows.push_back(dir_row(OP_GET,    0,   0,            0,   1, ST_RANGE, 0, 0));
        dir_rows.push_back(dir_row(OP_REMOVE, 0,   0,            0,   1, ST_EMPTY, 0, 0));
        dir_rows.push_back(dir_row(OP_SET,    0,   32'hDEADBEEF, 0,   1, ST_RANGE, 0, 0));
        dir_rows.push_back(dir_row(OP_INSERT, 1,   32'h5,        0,   1, ST_RANGE, 0, 0));
        dir_rows.push_back(dir_row(OP_RESIZE, 0,   0,            65,  1, ST_FULL,  0, 0));
        dir_rows.push_back(dir_row(OP_RESIZE, 0,   0,            127, 1, ST_FULL,  0, 0));
        dir_rows.push_back(dir_row(OP_RESIZE, 0,   0,            3,   1, ST_OK,    0, 3));
        dir_rows.push_back(dir_row(OP_GET,    2,   0,            0,   1, ST_OK,    0, 3));
        dir_rows.push_back(dir_row(OP_INSERT, 0,   32'hFFFFFFFF, 0,   1, ST_OK,    0, 4));
        dir_rows.push_back(dir_row(OP_INSERT, 4,   32'h12345678, 0,   1, ST_OK,    0, 5));
        dir_rows.push_back(dir_row(OP_SET,    2,   32'hA5A5A5A5, 0,   1, ST_OK,    0, 5));
        dir_rows.push_back(dir_row(OP_GET,    0,   0,            0,   1, ST_OK,
                                   32'hFFFFFFFF, 5));
        dir_rows.push_back(dir_row(OP_REMOVE, 127, 0,            0,   1, ST_RANGE, 0, 5));
        dir_rows.push_back(dir_row(OP_REMOVE, 0,   0,            0,   1, ST_OK,    0, 4));
        dir_rows.push_back(dir_row(OP_GET,    3,   0,            0,   1, ST_OK,
                                   32'h12345678, 4));
        // regrow over the slot left behind by the remove
        dir_rows.push_back(dir_row(OP_RESIZE, 0,   0,            5,   1, ST_OK,    0, 5));
        dir_rows.push_back(dir_row(OP_GET,    4,   0,            0,   0, ST_OK,    0, 0));
        dir_rows.push_back(dir_row(OP_UNUSED_LO, 0, 0,           0,   1, ST_OK,    0, 5));
        dir_rows.push_back(dir_row(OP_UNUSED_HI, 127, 32'hFFFFFFFF, 127, 1, ST_OK, 0, 5));
        dir_rows.push_back(dir_row(OP_RESIZE, 0,   0,            64,  1, ST_OK,    0, 64));
        dir_rows.push_back(dir_row(OP_INSERT, 64,  32'h1,        0,   1, ST_FULL,  0, 64));
        dir_rows.push_back(dir_row(OP_INSERT, 65,  32'h1,        0,   1, ST_RANGE, 0, 64));
        dir_rows.push_back(dir_row(OP_GET,    63,  0,            0,   0, ST_OK,    0, 0));
        dir_rows.push_back(dir_row(OP_REMOVE, 63,  0,            0,   1, ST_OK,    0, 63));
        dir_rows.push_back(dir_row(OP_CLEAR,  0,   0,            0,   1, ST_OK,    0, 0));
        dir_rows.push_back(dir_row(OP_GET,    0,   0,            0,   1, ST_RANGE, 0, 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < dir_rows.size(); k++) begin
            send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
        end

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 3) idle_mode = IDLE_DST_LIGHT;
            if (k == 2 * RANDOM_ITEMS / 3) idle_mode = IDLE_NONE;
            send_item(rand_item(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (reply_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0) $display("[indexed_array_list] OK");
        else $display("[indexed_array_list] ERROR");
        $finish;
    end

    // receiver; one long hold-off at the start of the no-idle phase
    initial begin
        bit held_off;
        held_off = 1'b0;
        forever begin
            @(posedge clk);
            if (idle_mode == IDLE_NONE && !held_off) begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (reply_q.size() == 0) begin
                err_cnt++;
                $display("%0t: result with none pending, expected none, got %p", $time,
                         out_data);
            end else begin
                head_reply = reply_q.pop_front();
                if (out_data.status !== head_reply.status) begin
                    err_cnt++;
                    $display("%0t: status expected %0d got %0d", $time,
                             head_reply.status, out_data.status);
                end
                if (out_data.read_value !== head_reply.read_value) begin
                    err_cnt++;
                    $display("%0t: read_value expected %h got %h", $time,
                             head_reply.read_value, out_data.read_value);
                end
                if (out_data.length !== head_reply.length) begin
                    err_cnt++;
                    $display("%0t: length expected %0d got %0d", $time,
                             head_reply.length, out_data.length);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[indexed_array_list] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
